FILE: hdl/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg: shared types and constants of the seven-bit frame encoder
// Result kinds, range limits and the command word that the front end
// hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package sbfe_pkg;

    // Range limits on the first byte of a message
    localparam logic [4:0] ADDRESS_LIMIT = 5'd8;
    localparam logic [4:0] LENGTH_LIMIT  = 5'd16;

    // Frame constants
    localparam logic [7:0] HEADER_MARK = 8'h80;
    localparam logic [2:0] LAST_REM    = 3'd6;

    // Command queue depth
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PACKET   = 2'd1,
        KIND_CHECKSUM = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    // One result of the frame
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       end_of_frame;
    } t_result;

    // All results caused by one request, with the index of the last one
    typedef struct packed {
        t_result [3:0] ent;
        logic [1:0]    last;
    } t_cmd;

endpackage

FILE: hdl/sbfe_if.sv
// ----------------------------------------------------------------------------
// sbfe_if: request channels of the seven-bit frame encoder
// Input channel carries message bytes, output channel carries frame bytes.
// ----------------------------------------------------------------------------
interface sbfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [3:0] address;
    logic [4:0] message_length;

    modport source (output valid, output data_byte, output address,
                    output message_length, input ready);
    modport sink   (input valid, input data_byte, input address,
                    input message_length, output ready);
endinterface

interface sbfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       end_of_frame;

    modport source (output valid, output out_byte, output kind,
                    output end_of_frame, input ready);
    modport sink   (input valid, input out_byte, input kind,
                    input end_of_frame, output ready);
endinterface

FILE: hdl/seven_bit_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// seven_bit_frame_encoder_top: seven-bit frame encoder with XOR checksum
//
// Input channel i_in takes one message byte per request; address and
// message_length are read on the first byte of a message only. A bad
// address or length gives a single error result with end_of_frame set.
// A good message gives a header byte, then the bytes re-cut MSB first
// into 7-bit packets, and after the last byte the padded partial packet
// and the 7-bit XOR checksum, the latter with end_of_frame set.
// Output channel o_out gives one frame byte per request.
// A request's results pass through the command queue to the output register.
// Throughput: one result per cycle at the output register unless the receiver
// stalls, and a request causes one to four results; the front end
// takes a request every cycle while the two-entry command queue has room.
// Reset clears message state, the queue and the output valid.
// A receiver stall holds the output register; the queue then fills and
// i_in.ready drops.
// ----------------------------------------------------------------------------
module seven_bit_frame_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = sbfe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbfe_in_if.sink     i_in,
    sbfe_out_if.source  o_out
);

    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    sbfe_pkg::t_cmd push_cmd;
    sbfe_pkg::t_cmd head_cmd;

    // Classify requests and build result lists
    sbfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    // Decouple front and back end
    sbfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Deliver results
    sbfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: hdl/sbfe_front.sv
// ----------------------------------------------------------------------------
// sbfe_front: request classifier and bit packer
// Checks the first byte of a message, tracks the bit stream state and
// builds the full list of results for each accepted request.
// ----------------------------------------------------------------------------
module sbfe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sbfe_in_if.sink             i_in,
    output logic                o_push,
    output sbfe_pkg::t_cmd      o_cmd,
    input  logic                i_full
);

    logic       r_in_msg;
    logic [3:0] r_pos;
    logic [3:0] r_exp;
    logic [2:0] r_rem;
    logic [6:0] r_pend;
    logic [6:0] r_xor;

    logic       n_in_msg;
    logic [3:0] n_pos;
    logic [3:0] n_exp;
    logic [2:0] n_rem;
    logic [6:0] n_pend;
    logic [6:0] n_xor;

    logic           acc;
    sbfe_pkg::t_cmd cmd;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign o_push     = acc;
    assign o_cmd      = cmd;

    // Classify the request and build its results
    always_comb begin
        logic       start;
        logic       bad;
        logic [3:0] pos;
        logic [3:0] expct;
        logic [2:0] rr;
        logic [6:0] pend;
        logic [6:0] xr;
        logic [3:0] shamt;
        logic [6:0] pkt1;
        logic [7:0] mask;
        logic [7:0] left;
        logic [7:0] left_sh;
        logic [6:0] pend_new;
        logic       full;
        logic       last;
        logic [6:0] xr2;
        logic [6:0] csum;
        logic [2:0] n;

        start    = !r_in_msg;
        bad      = start && ((5'(i_in.address) >= sbfe_pkg::ADDRESS_LIMIT)
                   || (i_in.message_length == 5'd0)
                   || (i_in.message_length >= sbfe_pkg::LENGTH_LIMIT));
        pos      = start ? 4'd0 : r_pos;
        expct    = start ? i_in.message_length[3:0] : r_exp;
        rr       = start ? 3'd0 : r_rem;
        pend     = start ? 7'd0 : r_pend;
        xr       = start ? 7'd0 : r_xor;

        shamt    = 4'(rr) + 4'd1;
        pkt1     = pend | 7'(i_in.data_byte >> shamt);
        mask     = 8'((9'd1 << shamt) - 9'd1);
        left     = i_in.data_byte & mask;
        left_sh  = left << (3'd6 - rr);
        full     = (rr == sbfe_pkg::LAST_REM);
        pend_new = full ? 7'd0 : left_sh[6:0];
        last     = ((5'(pos) + 5'd1) >= 5'(expct));
        xr2      = xr ^ pkt1 ^ (full ? left[6:0] : 7'd0);
        csum     = xr2 ^ pend_new;

        cmd = '0;
        n   = 3'd0;
        if (bad) begin
            cmd.ent[0] = '{out_byte: 8'd0, kind: sbfe_pkg::KIND_ERROR,
                           end_of_frame: 1'b1};
            n = 3'd1;
        end else begin
            if (start) begin
                cmd.ent[n[1:0]] = '{out_byte: sbfe_pkg::HEADER_MARK
                                    | {1'b0, i_in.address[2:0], 4'd0}
                                    | {4'd0, 4'(i_in.message_length - 5'd1)},
                                    kind: sbfe_pkg::KIND_HEADER,
                                    end_of_frame: 1'b0};
                n = n + 3'd1;
            end
            cmd.ent[n[1:0]] = '{out_byte: {1'b0, pkt1},
                                kind: sbfe_pkg::KIND_PACKET, end_of_frame: 1'b0};
            n = n + 3'd1;
            if (full) begin
                cmd.ent[n[1:0]] = '{out_byte: {1'b0, left[6:0]},
                                    kind: sbfe_pkg::KIND_PACKET, end_of_frame: 1'b0};
                n = n + 3'd1;
            end
            if (last) begin
                if (!full) begin
                    cmd.ent[n[1:0]] = '{out_byte: {1'b0, pend_new},
                                        kind: sbfe_pkg::KIND_PACKET,
                                        end_of_frame: 1'b0};
                    n = n + 3'd1;
                end
                cmd.ent[n[1:0]] = '{out_byte: {1'b0, csum},
                                    kind: sbfe_pkg::KIND_CHECKSUM,
                                    end_of_frame: 1'b1};
                n = n + 3'd1;
            end
        end
        cmd.last = 2'(n - 3'd1);

        // Advance the message state
        n_in_msg = r_in_msg;
        n_pos    = r_pos;
        n_exp    = r_exp;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_xor    = r_xor;
        if (acc && !bad) begin
            if (last) begin
                n_in_msg = 1'b0;
                n_pos    = 4'd0;
                n_exp    = 4'd0;
                n_rem    = 3'd0;
                n_pend   = 7'd0;
                n_xor    = 7'd0;
            end else begin
                n_in_msg = 1'b1;
                n_pos    = pos + 4'd1;
                n_exp    = expct;
                n_rem    = full ? 3'd0 : rr + 3'd1;
                n_pend   = pend_new;
                n_xor    = xr2;
            end
        end
    end

    // Hold the message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_pos    <= 4'd0;
            r_exp    <= 4'd0;
            r_rem    <= 3'd0;
            r_pend   <= 7'd0;
            r_xor    <= 7'd0;
        end else begin
            r_in_msg <= n_in_msg;
            r_pos    <= n_pos;
            r_exp    <= n_exp;
            r_rem    <= n_rem;
            r_pend   <= n_pend;
            r_xor    <= n_xor;
        end
    end

endmodule

FILE: hdl/sbfe_queue.sv
// ----------------------------------------------------------------------------
// sbfe_queue: command queue between front and back end
// Small register FIFO of command words so each side can stall on its own.
// ----------------------------------------------------------------------------
module sbfe_queue #(
    parameter int unsigned DEPTH = sbfe_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sbfe_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output sbfe_pkg::t_cmd      o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sbfe_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store command words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

FILE: hdl/sbfe_back.sv
// ----------------------------------------------------------------------------
// sbfe_back: result sequencer
// Walks the results of the queued command, one per cycle unless the receiver
// stalls, into the output register and pops the command after its last result.
// ----------------------------------------------------------------------------
module sbfe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sbfe_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    sbfe_out_if.source          o_out
);

    logic              r_valid;
    sbfe_pkg::t_result r_res;
    logic [1:0]        r_idx;

    logic load;

    assign load  = i_valid && (!r_valid || o_out.ready);
    assign o_pop = load && (r_idx == i_cmd.last);

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.kind         = 2'(r_res.kind);
    assign o_out.end_of_frame = r_res.end_of_frame;

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_cmd.ent[r_idx];
        end
    end

    // Track output valid and the result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/sbfe_checker.sv
// ----------------------------------------------------------------------------
// sbfe_checker: port checks of the seven-bit frame encoder
// Watches the output channel for stall behavior and result formats.
// ----------------------------------------------------------------------------
module sbfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_kind,
    input logic       i_out_eof
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
        && $stable(i_out_kind) && $stable(i_out_eof))
        else $error("stalled result changed");

    // Error result is a zero byte that ends the frame
    a_err_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == sbfe_pkg::KIND_ERROR
        |-> i_out_eof && i_out_byte == 8'd0)
        else $error("bad error result");

    // Frame ends only on checksum or error
    a_eof_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eof |-> i_out_kind == sbfe_pkg::KIND_CHECKSUM
        || i_out_kind == sbfe_pkg::KIND_ERROR)
        else $error("end of frame on wrong kind");

    // Header carries the mark bit and does not end the frame
    a_hdr_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == sbfe_pkg::KIND_HEADER
        |-> i_out_byte[7] && !i_out_eof)
        else $error("bad header");

    // Packets and checksum are seven bits wide
    a_pkt_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == sbfe_pkg::KIND_PACKET
        || i_out_kind == sbfe_pkg::KIND_CHECKSUM) |-> !i_out_byte[7])
        else $error("packet wider than seven bits");

endmodule

bind seven_bit_frame_encoder_top sbfe_checker u_sbfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.kind),
    .i_out_eof   (o_out.end_of_frame)
);

FILE: tb/sv/sbfe_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbfe_frame_checker: frame predictor and result checker
// Watches both channels of the seven-bit frame encoder. Every accepted
// input request is run through a frame predictor, which queues the frame
// bytes it must cause; every accepted output request is compared field by
// field with the oldest queued byte. Mismatches and unexpected results are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module sbfe_frame_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sbfe_in_if    i_req_mon,
    sbfe_out_if   i_res_mon,
    output int    o_fail_count,
    output int    o_pending_results
);

    // Predictor copy of the message state
    logic       msg_active;
    logic [3:0] byte_idx;
    logic [3:0] msg_len;
    logic [6:0] carry_bits;
    logic [6:0] frame_xor;

    // Frame bytes still owed by the block, oldest first
    sbfe_pkg::t_result expected_frame_q[$];

    initial begin
        o_fail_count      = 0;
        o_pending_results = 0;
    end

    task automatic queue_frame_byte(input logic [7:0] val, input sbfe_pkg::t_kind kd,
                                    input logic eof);
        sbfe_pkg::t_result res;
        res.out_byte     = val;
        res.kind         = kd;
        res.end_of_frame = eof;
        expected_frame_q.push_back(res);
    endtask

    task automatic clear_message();
        msg_active = 1'b0;
        byte_idx   = '0;
        msg_len    = '0;
        carry_bits = '0;
        frame_xor  = '0;
    endtask

    // Work out the frame bytes caused by one input request
    task automatic encode_request(input logic [7:0] data, input logic [3:0] addr,
                                  input logic [4:0] len);
        int         rem;
        int         left;
        logic [6:0] pkt;
        logic [4:0] len_m1;

        if (!msg_active) begin
            // Reject a bad first byte and stay idle
            if (addr >= sbfe_pkg::ADDRESS_LIMIT || len == 5'd0
                || len >= sbfe_pkg::LENGTH_LIMIT) begin
                queue_frame_byte(8'h00, sbfe_pkg::KIND_ERROR, 1'b1);
                return;
            end
            msg_active = 1'b1;
            byte_idx   = '0;
            msg_len    = len[3:0];
            carry_bits = '0;
            frame_xor  = '0;
            len_m1     = len - 5'd1;
            queue_frame_byte(sbfe_pkg::HEADER_MARK | {1'b0, addr[2:0], len_m1[3:0]},
                             sbfe_pkg::KIND_HEADER, 1'b0);
        end

        rem = int'(byte_idx) % 7;

        // Complete the open packet with the top bits of the byte
        pkt = carry_bits | 7'(int'(data) >> (rem + 1));
        queue_frame_byte({1'b0, pkt}, sbfe_pkg::KIND_PACKET, 1'b0);
        frame_xor ^= pkt;

        // Hold the low bits over; a full seven of them form a packet at once
        left = int'(data) & ((1 << (rem + 1)) - 1);
        if (rem == int'(sbfe_pkg::LAST_REM)) begin
            pkt = 7'(left);
            queue_frame_byte({1'b0, pkt}, sbfe_pkg::KIND_PACKET, 1'b0);
            frame_xor ^= pkt;
            carry_bits = '0;
        end else begin
            carry_bits = 7'(left << (6 - rem));
        end

        // Flush the padded partial packet and close with the checksum
        if (int'(byte_idx) + 1 >= int'(msg_len)) begin
            if (rem != int'(sbfe_pkg::LAST_REM)) begin
                queue_frame_byte({1'b0, carry_bits}, sbfe_pkg::KIND_PACKET, 1'b0);
                frame_xor ^= carry_bits;
            end
            queue_frame_byte({1'b0, frame_xor}, sbfe_pkg::KIND_CHECKSUM, 1'b1);
            clear_message();
        end else begin
            byte_idx = byte_idx + 4'd1;
        end
    endtask

    // Compare one output request with the oldest owed frame byte
    task automatic check_frame_byte();
        sbfe_pkg::t_result want;

        if (expected_frame_q.size() == 0) begin
            $error("unexpected result: out_byte=0x%02h kind=%0d end_of_frame=%0b",
                   i_res_mon.out_byte, i_res_mon.kind, i_res_mon.end_of_frame);
            o_fail_count++;
            return;
        end
        want = expected_frame_q.pop_front();
        if (i_res_mon.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                   want.out_byte, i_res_mon.out_byte);
            o_fail_count++;
        end
        if (i_res_mon.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d",
                   want.kind, i_res_mon.kind);
            o_fail_count++;
        end
        if (i_res_mon.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame mismatch: expected %0b, actual %0b",
                   want.end_of_frame, i_res_mon.end_of_frame);
            o_fail_count++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            expected_frame_q.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                encode_request(i_req_mon.data_byte, i_req_mon.address,
                               i_req_mon.message_length);
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                check_frame_byte();
            end
        end
        o_pending_results = expected_frame_q.size();
    end

endmodule

FILE: tb/sv/tb_seven_bit_frame_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_bit_frame_encoder_top: testbench of the seven-bit frame encoder
// Sends rejected first bytes and well-formed messages of every length,
// first a directed set at the edges of the packing, then random messages
// over phases of sender idling and receiver stalling, including one long
// receiver hold-off that backs the block up. A checker beside the block
// predicts every frame byte and compares it with what comes out.
// ----------------------------------------------------------------------------
module tb_seven_bit_frame_encoder_top;

    localparam int RANDOM_ITEMS  = 185;
    localparam int RX_HOLD_LEN   = 200;

    logic i_clk;
    logic i_rst_n;

    int   fail_count;
    int   pending_results;
    int   items_sent;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic rx_hold_go;

    sbfe_in_if  req_ch ();
    sbfe_out_if res_ch ();

    seven_bit_frame_encoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    sbfe_frame_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_mon         (req_ch),
        .i_res_mon         (res_ch),
        .o_fail_count      (fail_count),
        .o_pending_results (pending_results)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("seven_bit_frame_encoder_top test failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_go && !hold_done) begin
                hold_left = RX_HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one input request and hold it until accepted
    task automatic send_byte(input logic [7:0] data, input logic [3:0] addr,
                             input logic [4:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.data_byte      = data;
        req_ch.address        = addr;
        req_ch.message_length = len;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Send a whole message; fields after the first byte are random noise
    task automatic send_message(input logic [3:0] addr, input logic [4:0] len);
        send_byte(8'($urandom), addr, len);
        for (int i = 1; i < int'(len); i++) begin
            send_byte(8'($urandom), 4'($urandom), 5'($urandom_range(16)));
        end
    endtask

    // Send a first byte that the block must reject
    task automatic send_bad_header();
        case ($urandom_range(2))
            0: send_byte(8'($urandom), 4'($urandom_range(15, 8)),
                         5'($urandom_range(16)));
            1: send_byte(8'($urandom), 4'($urandom_range(7)), 5'd0);
            default: send_byte(8'($urandom), 4'($urandom_range(7)),
                               sbfe_pkg::LENGTH_LIMIT);
        endcase
    endtask

    // Drain: stop offering until every owed frame byte has come out
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        wait (pending_results == 0);
        @(negedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        int rnd_base;
        int phase;
        int last_phase;

        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.data_byte      = '0;
        req_ch.address        = '0;
        req_ch.message_length = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        rx_hold_go            = 1'b0;
        items_sent            = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Rejected first bytes: address and length out of range
        send_byte(8'hFF, 4'd8, 5'd1);
        send_byte(8'h00, 4'd15, 5'd5);
        send_byte(8'hA5, 4'd0, 5'd0);
        send_byte(8'h5A, 4'd7, 5'd16);

        // Single-byte messages at the extremes
        send_byte(8'h00, 4'd0, 5'd1);
        send_byte(8'hFF, 4'd7, 5'd1);

        // Second byte carries bad fields that must be ignored
        send_byte(8'h80, 4'd3, 5'd2);
        send_byte(8'h01, 4'd15, 5'd0);

        // Seven bytes: last one lands on a packet boundary, no flush
        send_byte(8'hFF, 4'd5, 5'd7);
        send_byte(8'h00, 4'd0, 5'd0);
        send_byte(8'hAA, 4'd0, 5'd0);
        send_byte(8'h55, 4'd0, 5'd0);
        send_byte(8'h80, 4'd0, 5'd0);
        send_byte(8'h01, 4'd0, 5'd0);
        send_byte(8'hFF, 4'd0, 5'd0);

        // Longest legal message
        send_message(4'd6, 5'd15);
        wait_drained();

        // Long receiver hold-off while the sender keeps pushing
        rx_hold_go = 1'b1;

        rnd_base   = items_sent;
        last_phase = 0;
        while (items_sent - rnd_base < RANDOM_ITEMS) begin
            phase = (items_sent - rnd_base) * 4 / RANDOM_ITEMS;
            if (phase != last_phase) begin
                wait_drained();
                last_phase = phase;
                case (phase)
                    1: begin
                        send_idle_pct  = 59;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 59;
                    end
                    default: begin
                        send_idle_pct  = 26;
                        recv_stall_pct = 26;
                    end
                endcase
            end
            if ($urandom_range(99) < 15) begin
                send_bad_header();
            end else begin
                send_message(4'($urandom_range(7)), 5'($urandom_range(15, 1)));
            end
        end

        // Wait for the last frame, then wait on for stragglers
        req_ch.valid = 1'b0;
        wait (pending_results == 0);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("seven_bit_frame_encoder_top test passed");
        end else begin
            $display("seven_bit_frame_encoder_top test failed");
        end
        $finish;
    end

endmodule
